FILE: sv/pnjlt_pkg.sv
// shared widths, codes and defaults for the per-node job limit table
package pnjlt_pkg;

	localparam int NODES_DEF = 32;

	localparam int OP_W = 2;
	localparam int IDX_W = 5;
	localparam int LVL_W = 3;
	localparam int MAX_W = 16;
	localparam int PEERS_W = 10;
	localparam int EXT_W = 11;

	localparam logic [MAX_W-1:0] DEFAULT_JOB_MAX_RST = 16'd2;

	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_NODE_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_TOTAL_QUERY = 2'd2;

	localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
	localparam logic [LVL_W-1:0] LVL_LOW = 3'd1;
	localparam logic [LVL_W-1:0] LVL_MED = 3'd2;
	localparam logic [LVL_W-1:0] LVL_HIGH = 3'd3;
	localparam logic [LVL_W-1:0] LVL_EXTREME = 3'd4;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [MAX_W-1:0] job_max;
	} entry_t;

	function automatic logic [MAX_W-1:0] at_least_one(input logic [MAX_W-1:0] v);
		at_least_one = (v == '0) ? MAX_W'(1) : v;
	endfunction

	function automatic logic [MAX_W-1:0] node_limit(input logic [LVL_W-1:0] lvl,
			input logic [MAX_W-1:0] mx);
		logic [MAX_W-1:0] r;
		r = MAX_W'(1);
		unique case (lvl)
			LVL_MED: r = at_least_one(mx >> 2);
			LVL_LOW: r = at_least_one(mx >> 1);
			LVL_NONE: r = at_least_one(mx);
			default: r = MAX_W'(1);
		endcase
		node_limit = r;
	endfunction

endpackage

FILE: sv/per_node_job_limit_table.sv
// per-node job limit table: record store, node limit and cluster limit scan
//
// channel  | valid      | ready      | payload
// ---------+------------+------------+-----------------------------------------------
// cfg      | cfg_valid  | cfg_ready  | cfg_data (default job maximum)
// in       | in_valid   | in_ready   | op, node_index, load_level, node_job_max,
//          |            |            | batch_limit, active_peers
// out      | out_valid  | out_ready  | job_limit, level_unrecognized
//
// an update is written on acceptance; a node query goes through ST_NODE and ST_DONE;
// a total query scans all records: one record per cycle through the record ram port.
// in_ready is high only when the sequencer is idle; a finished result waits in the
// output register, and a further result waits for that register to free up.
// reset clears the valid bits and sets the default job maximum to 2.
module per_node_job_limit_table #(
	parameter int NODES = pnjlt_pkg::NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pnjlt_pkg::MAX_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pnjlt_pkg::OP_W-1:0]     op,
	input  logic [pnjlt_pkg::IDX_W-1:0]    node_index,
	input  logic [pnjlt_pkg::LVL_W-1:0]    load_level,
	input  logic [pnjlt_pkg::MAX_W-1:0]    node_job_max,
	input  logic [pnjlt_pkg::MAX_W-1:0]    batch_limit,
	input  logic [pnjlt_pkg::PEERS_W-1:0]  active_peers,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pnjlt_pkg::MAX_W-1:0]    job_limit,
	output logic                           level_unrecognized
);

	localparam int AddrW = $clog2(NODES);
	localparam int CntW = $clog2(NODES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NODE = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [pnjlt_pkg::MAX_W-1:0] dflt_max_q;
	logic [NODES-1:0] valid_q;
	pnjlt_pkg::entry_t mem [NODES];
	pnjlt_pkg::entry_t rd_q;

	logic [AddrW-1:0] addr_q;
	logic in_range_q;
	logic hit_s1;
	logic scan_s1;
	logic [CntW-1:0] cnt_q;
	logic [pnjlt_pkg::PEERS_W-1:0] peers_q;
	logic [pnjlt_pkg::MAX_W-1:0] lim_q;
	logic unrec_q;

	logic out_valid_q;
	logic [pnjlt_pkg::MAX_W-1:0] out_lim_q;
	logic out_unrec_q;

	logic [pnjlt_pkg::EXT_W-1:0] idx_ext;
	logic [AddrW-1:0] in_addr;
	logic in_range;
	logic in_acc;
	logic scan_more;

	logic rd_en;
	logic [AddrW-1:0] rd_addr;
	logic wr_en;
	logic [AddrW-1:0] wr_addr;
	pnjlt_pkg::entry_t wr_data;

	pnjlt_pkg::entry_t node_entry;
	logic [pnjlt_pkg::MAX_W-1:0] q_lim;
	logic [pnjlt_pkg::MAX_W-1:0] h_lim;
	logic [pnjlt_pkg::MAX_W-1:0] scan_next;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;

	assign idx_ext = {{(pnjlt_pkg::EXT_W - pnjlt_pkg::IDX_W){1'b0}}, node_index};
	assign in_addr = idx_ext[AddrW-1:0];
	assign in_range = idx_ext < pnjlt_pkg::EXT_W'(NODES);
	assign scan_more = (cnt_q != CntW'(NODES));

	assign out_free = !out_valid_q || out_ready;

	// a node that was never seen reads as level low with the default maximum
	assign node_entry = hit_s1 ? rd_q :
		pnjlt_pkg::entry_t'{level: pnjlt_pkg::LVL_LOW, job_max: dflt_max_q};

	assign q_lim = pnjlt_pkg::at_least_one(pnjlt_pkg::MAX_W'(peers_q >> 2));
	assign h_lim = pnjlt_pkg::at_least_one(pnjlt_pkg::MAX_W'(peers_q >> 1));

	always_comb begin
		scan_next = lim_q;
		if (scan_s1) begin
			if (rd_q.level == pnjlt_pkg::LVL_EXTREME) begin
				if (lim_q == '0 || lim_q > q_lim) scan_next = q_lim;
			end else if (rd_q.level == pnjlt_pkg::LVL_HIGH) begin
				if (lim_q == '0 || lim_q > h_lim) scan_next = h_lim;
			end
		end
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = in_addr;
		if (state_q == ST_IDLE) begin
			rd_en = in_valid && in_range;
		end else if (state_q == ST_SCAN) begin
			rd_en = scan_more;
			rd_addr = cnt_q[AddrW-1:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = in_addr;
		wr_data = '{level: load_level, job_max: node_job_max};
		if (state_q == ST_NODE) begin
			wr_en = in_range_q && !hit_s1;
			wr_addr = addr_q;
			wr_data = node_entry;
		end else if (in_acc && op == pnjlt_pkg::OP_UPDATE) begin
			wr_en = in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_max_q <= pnjlt_pkg::DEFAULT_JOB_MAX_RST;
		end else if (cfg_valid) begin
			dflt_max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			hit_s1 <= 1'b0;
			scan_s1 <= 1'b0;
			in_range_q <= 1'b0;
			cnt_q <= '0;
			peers_q <= '0;
			lim_q <= '0;
			unrec_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						addr_q <= in_addr;
						in_range_q <= in_range;
						hit_s1 <= in_range && valid_q[in_addr];
						lim_q <= batch_limit;
						peers_q <= active_peers;
						cnt_q <= '0;
						scan_s1 <= 1'b0;
						unrec_q <= 1'b0;
						if (op == pnjlt_pkg::OP_NODE_QUERY) state_q <= ST_NODE;
						else if (op == pnjlt_pkg::OP_TOTAL_QUERY) state_q <= ST_SCAN;
					end
				end
				ST_NODE: begin
					if (in_range_q) begin
						lim_q <= pnjlt_pkg::node_limit(node_entry.level, node_entry.job_max);
						unrec_q <= node_entry.level > pnjlt_pkg::LVL_EXTREME;
					end else begin
						lim_q <= pnjlt_pkg::MAX_W'(1);
						unrec_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					// read of record cnt issued now, its data checked next cycle
					lim_q <= scan_next;
					if (scan_more) begin
						scan_s1 <= valid_q[cnt_q[AddrW-1:0]];
						cnt_q <= cnt_q + CntW'(1);
					end else begin
						scan_s1 <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_lim_q <= lim_q;
			out_unrec_q <= unrec_q;
		end
	end

	assign out_valid = out_valid_q;
	assign job_limit = out_lim_q;
	assign level_unrecognized = out_unrec_q;

endmodule

FILE: sim/tb_per_node_job_limit_table.sv
// testbench for the per-node job limit table: directed table, random traffic and a live predictor
module tb_per_node_job_limit_table;

	localparam logic [pnjlt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [pnjlt_pkg::LVL_W-1:0] LVL_UNKNOWN = 3'd5;
	localparam logic [pnjlt_pkg::LVL_W-1:0] LVL_RSVD7 = 3'd7;
	localparam int DRAIN_CYCLES = 50;
	localparam int LIMIT_CYCLES = 500000;
	localparam int PHASE_ITEMS = 230;

	typedef struct packed {
		logic [pnjlt_pkg::OP_W-1:0] op;
		logic [pnjlt_pkg::IDX_W-1:0] idx;
		logic [pnjlt_pkg::LVL_W-1:0] lvl;
		logic [pnjlt_pkg::MAX_W-1:0] mx;
		logic [pnjlt_pkg::MAX_W-1:0] batch;
		logic [pnjlt_pkg::PEERS_W-1:0] peers;
	} job_req_t;

	typedef struct packed {
		logic [pnjlt_pkg::MAX_W-1:0] lim;
		logic unrec;
	} limit_t;

	typedef struct packed {
		job_req_t req;
		logic typed;
		limit_t lim;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pnjlt_pkg::MAX_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pnjlt_pkg::OP_W-1:0] op = '0;
	logic [pnjlt_pkg::IDX_W-1:0] node_index = '0;
	logic [pnjlt_pkg::LVL_W-1:0] load_level = '0;
	logic [pnjlt_pkg::MAX_W-1:0] node_job_max = '0;
	logic [pnjlt_pkg::MAX_W-1:0] batch_limit = '0;
	logic [pnjlt_pkg::PEERS_W-1:0] active_peers = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pnjlt_pkg::MAX_W-1:0] job_limit;
	logic level_unrecognized;

	// predictor copy of the record table and the default maximum
	bit rec_valid [pnjlt_pkg::NODES_DEF];
	logic [pnjlt_pkg::LVL_W-1:0] rec_level [pnjlt_pkg::NODES_DEF];
	logic [pnjlt_pkg::MAX_W-1:0] rec_max [pnjlt_pkg::NODES_DEF];
	logic [pnjlt_pkg::MAX_W-1:0] default_max = pnjlt_pkg::DEFAULT_JOB_MAX_RST;

	limit_t limits_due [$];
	dir_row_t dir_rows [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int n_errors = 0;
	int n_sent = 0;
	int n_node_q = 0;
	int n_total_q = 0;
	int n_results = 0;
	int n_cfg = 0;
	int n_cycles = 0;

	per_node_job_limit_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.node_index(node_index),
		.load_level(load_level),
		.node_job_max(node_job_max),
		.batch_limit(batch_limit),
		.active_peers(active_peers),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.job_limit(job_limit),
		.level_unrecognized(level_unrecognized)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// applies one accepted request to the table copy, returns 1 when a result is due
	function automatic bit predict_limit(input job_req_t r, output limit_t res);
		int unsigned lim;
		int unsigned q;
		int unsigned h;
		res = '0;
		case (r.op)
			pnjlt_pkg::OP_UPDATE: begin
				rec_valid[r.idx] = 1'b1;
				rec_level[r.idx] = r.lvl;
				rec_max[r.idx] = r.mx;
				return 1'b0;
			end
			pnjlt_pkg::OP_NODE_QUERY: begin
				if (!rec_valid[r.idx]) begin
					rec_valid[r.idx] = 1'b1;
					rec_level[r.idx] = pnjlt_pkg::LVL_LOW;
					rec_max[r.idx] = default_max;
				end
				case (rec_level[r.idx])
					pnjlt_pkg::LVL_NONE: lim = rec_max[r.idx];
					pnjlt_pkg::LVL_LOW: lim = rec_max[r.idx] >> 1;
					pnjlt_pkg::LVL_MED: lim = rec_max[r.idx] >> 2;
					default: lim = 0;
				endcase
				res.lim = pnjlt_pkg::MAX_W'((lim == 0) ? 1 : lim);
				res.unrec = (rec_level[r.idx] > pnjlt_pkg::LVL_EXTREME);
				return 1'b1;
			end
			pnjlt_pkg::OP_TOTAL_QUERY: begin
				lim = r.batch;
				q = r.peers >> 2;
				h = r.peers >> 1;
				for (int i = 0; i < pnjlt_pkg::NODES_DEF; i++) begin
					if (rec_valid[i] && rec_level[i] == pnjlt_pkg::LVL_EXTREME) begin
						if (lim == 0 || lim > q)
							lim = (q == 0) ? 1 : q;
					end else if (rec_valid[i] && rec_level[i] == pnjlt_pkg::LVL_HIGH) begin
						if (lim == 0 || lim > h)
							lim = (h == 0) ? 1 : h;
					end
				end
				res.lim = pnjlt_pkg::MAX_W'(lim);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// nodes kept unknown until a given phase, so each default gets filled into some records
	function automatic int node_phase(input int n);
		if (n >= 1 && n <= 5)
			return 0;
		if (n >= 6 && n <= 10)
			return 1;
		if (n >= 11 && n <= 15)
			return 2;
		if (n >= 16 && n <= 21)
			return 3;
		return 0;
	endfunction

	function automatic logic [pnjlt_pkg::MAX_W-1:0] rand_count16();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return pnjlt_pkg::MAX_W'($urandom_range(1, 3));
			2: return '1;
			3: return pnjlt_pkg::MAX_W'($urandom_range(4, 64));
			default: return pnjlt_pkg::MAX_W'($urandom);
		endcase
	endfunction

	function automatic logic [pnjlt_pkg::PEERS_W-1:0] rand_peers();
		case ($urandom_range(0, 3))
			0: return pnjlt_pkg::PEERS_W'($urandom_range(0, 7));
			1: return '1;
			default: return pnjlt_pkg::PEERS_W'($urandom);
		endcase
	endfunction

	// calm requests keep high and extreme out of the table so the plain batch path shows up
	function automatic job_req_t rand_request(input int ph, input bit mixed);
		job_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.op = pnjlt_pkg::OP_UPDATE;
		else if (pick < 70)
			r.op = pnjlt_pkg::OP_NODE_QUERY;
		else if (pick < 95)
			r.op = pnjlt_pkg::OP_TOTAL_QUERY;
		else
			r.op = OP_UNUSED;
		do r.idx = pnjlt_pkg::IDX_W'($urandom_range(0, pnjlt_pkg::NODES_DEF - 1));
		while (node_phase(r.idx) > ph);
		do r.lvl = pnjlt_pkg::LVL_W'($urandom_range(0, 7));
		while (!mixed && (r.lvl == pnjlt_pkg::LVL_HIGH || r.lvl == pnjlt_pkg::LVL_EXTREME));
		r.mx = rand_count16();
		r.batch = rand_count16();
		r.peers = rand_peers();
		return r;
	endfunction

	function automatic void add_row(input logic [pnjlt_pkg::OP_W-1:0] o, input int idx,
			input logic [pnjlt_pkg::LVL_W-1:0] lvl, input int mx, input int batch,
			input int peers, input bit typed, input int lim, input bit unrec);
		dir_row_t row;
		row.req.op = o;
		row.req.idx = pnjlt_pkg::IDX_W'(idx);
		row.req.lvl = lvl;
		row.req.mx = pnjlt_pkg::MAX_W'(mx);
		row.req.batch = pnjlt_pkg::MAX_W'(batch);
		row.req.peers = pnjlt_pkg::PEERS_W'(peers);
		row.typed = typed;
		row.lim.lim = pnjlt_pkg::MAX_W'(lim);
		row.lim.unrec = unrec;
		dir_rows.push_back(row);
	endfunction

	// typed rows push their written-down result, the others the predicted one
	task automatic send_request(input job_req_t r, input bit typed, input limit_t typed_lim);
		limit_t res;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		node_index <= r.idx;
		load_level <= r.lvl;
		node_job_max <= r.mx;
		batch_limit <= r.batch;
		active_peers <= r.peers;
		do @(posedge clk); while (!in_ready);
		if (predict_limit(r, res))
			limits_due.push_back(typed ? typed_lim : res);
		n_sent++;
		if (r.op == pnjlt_pkg::OP_NODE_QUERY)
			n_node_q++;
		if (r.op == pnjlt_pkg::OP_TOTAL_QUERY)
			n_total_q++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (limits_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_default(input logic [pnjlt_pkg::MAX_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		default_max = v;
		n_cfg++;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		limit_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (limits_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got job_limit %0d unrec %0b",
					$time, job_limit, level_unrecognized);
				n_errors++;
			end else begin
				want = limits_due.pop_front();
				if (job_limit !== want.lim) begin
					$display("%0t: job_limit expected %0d got %0d", $time, want.lim, job_limit);
					n_errors++;
				end
				if (level_unrecognized !== want.unrec) begin
					$display("%0t: level_unrecognized expected %0b got %0b", $time, want.unrec,
						level_unrecognized);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results pending", $time, limits_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		job_req_t r;
		int count;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, reset default of 2, every named level plus codes 5 and 7, op 3 left alone
		add_row(pnjlt_pkg::OP_TOTAL_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 0, 0);
		add_row(pnjlt_pkg::OP_TOTAL_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 65535, 1023, 1, 65535, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 31, pnjlt_pkg::LVL_NONE, 65535, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 31, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 65535, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 30, pnjlt_pkg::LVL_LOW, 65535, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 30, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 32767, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 29, pnjlt_pkg::LVL_MED, 65535, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 29, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 16383, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 28, pnjlt_pkg::LVL_MED, 3, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 28, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 27, pnjlt_pkg::LVL_NONE, 0, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 27, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 26, pnjlt_pkg::LVL_HIGH, 65535, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 26, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 25, pnjlt_pkg::LVL_EXTREME, 1000, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 25, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 0);
		add_row(pnjlt_pkg::OP_UPDATE, 24, LVL_UNKNOWN, 7, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 24, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 1);
		add_row(pnjlt_pkg::OP_UPDATE, 23, LVL_RSVD7, 65535, 0, 0, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 23, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 1, 1);
		add_row(pnjlt_pkg::OP_TOTAL_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 0, 1023, 1, 255, 0);
		add_row(pnjlt_pkg::OP_TOTAL_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 100, 1, 1, 1, 0);
		add_row(pnjlt_pkg::OP_TOTAL_QUERY, 0, pnjlt_pkg::LVL_NONE, 0, 300, 600, 0, 0, 0);
		add_row(OP_UNUSED, 31, LVL_RSVD7, 65535, 65535, 1023, 0, 0, 0);
		add_row(pnjlt_pkg::OP_NODE_QUERY, 31, pnjlt_pkg::LVL_NONE, 0, 0, 0, 1, 65535, 0);
		foreach (dir_rows[k])
			send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].lim);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					write_default('0);
				end
				1: begin
					idle_pct = 50;
					stall_pct = 0;
					write_default(pnjlt_pkg::MAX_W'(1));
				end
				2: begin
					idle_pct = 0;
					stall_pct = 50;
					write_default('1);
				end
				default: begin
					idle_pct = 29;
					stall_pct = 29;
					write_default(pnjlt_pkg::MAX_W'($urandom_range(3, 65534)));
				end
			endcase
			// first queries of this phase's unknown nodes pick up the new default
			for (int n = 0; n < pnjlt_pkg::NODES_DEF; n++) begin
				if (node_phase(n) == ph && !rec_valid[n]) begin
					r = rand_request(ph, 1'b1);
					r.op = pnjlt_pkg::OP_NODE_QUERY;
					r.idx = pnjlt_pkg::IDX_W'(n);
					send_request(r, 1'b0, '0);
				end
			end
			// wipe high and extreme levels from the known records
			for (int n = 0; n < pnjlt_pkg::NODES_DEF; n++) begin
				if (node_phase(n) <= ph && rec_valid[n]) begin
					r = rand_request(ph, 1'b0);
					r.op = pnjlt_pkg::OP_UPDATE;
					r.idx = pnjlt_pkg::IDX_W'(n);
					send_request(r, 1'b0, '0);
				end
			end
			count = 0;
			while (count < PHASE_ITEMS) begin
				r = rand_request(ph, count >= PHASE_ITEMS / 2);
				send_request(r, 1'b0, '0);
				if (r.op != OP_UNUSED)
					count++;
			end
		end

		wait_idle();
		$display("ran %0d requests: %0d node queries, %0d total queries, %0d results checked",
			n_sent, n_node_q, n_total_q, n_results);
		$display("%0d default writes, four handshake pressure phases, %0d mismatches",
			n_cfg, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
